### rtl/adpcm_nibble_decoder_macros.svh
// ---------------------------------------------------------------------------
// ADPCM nibble decoder assertion macros
// Shared concurrent assertion wrappers for the decoder RTL.
// ---------------------------------------------------------------------------
`ifndef ADPCM_NIBBLE_DECODER_MACROS_SVH
`define ADPCM_NIBBLE_DECODER_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ADND_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assertion on the block clock and reset.
`define ADND_ASSERT(lbl, prop, msg) \
  `ADND_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/adnd_pkg.sv
// ---------------------------------------------------------------------------
// ADPCM nibble decoder package
// Widths, limits, the step table and the index adaptation table.
// ---------------------------------------------------------------------------
package adnd_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned StepW   = 15;
  localparam int unsigned CodeW   = 4;

  localparam logic [IdxW-1:0] MaxIdx = 6'd48;
  localparam logic signed [SampleW-1:0] PredMax = 16'sd32767;
  localparam logic signed [SampleW-1:0] PredMin = -16'sd32767;

  // Result of decoding one code against one channel.
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic [IdxW-1:0]           idx;
  } lane_res_t;

  // One decoded sample pair as held in the output buffer.
  typedef struct packed {
    logic signed [SampleW-1:0] first_sample;
    logic signed [SampleW-1:0] second_sample;
    logic                      last_pair;
  } pcm_t;

  // Step sizes, already scaled for 16-bit output.
  function automatic logic [StepW-1:0] step_size(input logic [IdxW-1:0] idx);
    logic [StepW-1:0] s;
    case (idx)
      6'd0:  s = 15'd256;   6'd1:  s = 15'd272;   6'd2:  s = 15'd304;
      6'd3:  s = 15'd336;   6'd4:  s = 15'd368;   6'd5:  s = 15'd400;
      6'd6:  s = 15'd448;   6'd7:  s = 15'd496;   6'd8:  s = 15'd544;
      6'd9:  s = 15'd592;   6'd10: s = 15'd656;   6'd11: s = 15'd720;
      6'd12: s = 15'd800;   6'd13: s = 15'd880;   6'd14: s = 15'd960;
      6'd15: s = 15'd1056;  6'd16: s = 15'd1168;  6'd17: s = 15'd1280;
      6'd18: s = 15'd1408;  6'd19: s = 15'd1552;  6'd20: s = 15'd1712;
      6'd21: s = 15'd1888;  6'd22: s = 15'd2080;  6'd23: s = 15'd2288;
      6'd24: s = 15'd2512;  6'd25: s = 15'd2768;  6'd26: s = 15'd3040;
      6'd27: s = 15'd3344;  6'd28: s = 15'd3680;  6'd29: s = 15'd4048;
      6'd30: s = 15'd4464;  6'd31: s = 15'd4912;  6'd32: s = 15'd5392;
      6'd33: s = 15'd5936;  6'd34: s = 15'd6528;  6'd35: s = 15'd7184;
      6'd36: s = 15'd7904;  6'd37: s = 15'd8704;  6'd38: s = 15'd9568;
      6'd39: s = 15'd10528; 6'd40: s = 15'd11584; 6'd41: s = 15'd12736;
      6'd42: s = 15'd14016; 6'd43: s = 15'd15408; 6'd44: s = 15'd16960;
      6'd45: s = 15'd18656; 6'd46: s = 15'd20512; 6'd47: s = 15'd22576;
      default: s = 15'd24832;
    endcase
    return s;
  endfunction

  // Step index adjustment for the three magnitude bits of a code.
  function automatic logic signed [4:0] index_move(input logic [2:0] mag);
    logic signed [4:0] m;
    case (mag)
      3'd4:    m = 5'sd2;
      3'd5:    m = 5'sd4;
      3'd6:    m = 5'sd6;
      3'd7:    m = 5'sd8;
      default: m = -5'sd1;
    endcase
    return m;
  endfunction

endpackage

### rtl/adnd_ifs.sv
// ---------------------------------------------------------------------------
// ADPCM nibble decoder channel interfaces
// Valid/ready channels for coded bytes in and sample pairs out.
// ---------------------------------------------------------------------------
interface adnd_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       start_of_stream;
  logic       end_of_stream;

  modport source (output valid, code_byte, start_of_stream, end_of_stream, input ready);
  modport sink   (input valid, code_byte, start_of_stream, end_of_stream, output ready);
endinterface

interface adnd_pcm_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [adnd_pkg::SampleW-1:0]    first_sample;
  logic signed [adnd_pkg::SampleW-1:0]    second_sample;
  logic                                   last_pair;

  modport source (output valid, first_sample, second_sample, last_pair, input ready);
  modport sink   (input valid, first_sample, second_sample, last_pair, output ready);
endinterface

### rtl/adpcm_nibble_decoder.sv
// ---------------------------------------------------------------------------
// ADPCM nibble decoder top level
// Two-lane 4-bit ADPCM decoder producing one 16-bit sample pair per byte.
// ---------------------------------------------------------------------------
//
//  Channel   Role     Payload                                        Handshake
//  code_i    sink     code_byte, start_of_stream, end_of_stream      valid/ready
//  pcm_o     source   first_sample, second_sample, last_pair         valid/ready
//  cfg       write    cfg_wdata_i = stereo_mode                      cfg_we_i
//
//  A new byte is accepted every cycle while the output buffer's skid slot is empty;
//  the pair is registered into the buffer and presented on pcm_o from its main register.
//  The rate is set by the state update loop: both lanes, chained through
//  channel A in mono, settle combinationally.
//  Reset clears the predictors, the step indices, the mode and the buffer.
//  On a pcm_o stall the skid slot absorbs one more transaction, then code_i.ready drops.
//
module adpcm_nibble_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  adnd_code_if.sink  code_i,
  adnd_pcm_if.source pcm_o
);

  `include "adpcm_nibble_decoder_macros.svh"

  // Channel state. Indices always stay within the step table.
  logic signed [adnd_pkg::SampleW-1:0] pred_a_q, pred_a_d;
  logic signed [adnd_pkg::SampleW-1:0] pred_b_q, pred_b_d;
  logic [adnd_pkg::IdxW-1:0]           idx_a_q, idx_a_d;
  logic [adnd_pkg::IdxW-1:0]           idx_b_q, idx_b_d;
  logic                                stereo_q;

  logic                                in_fire;
  logic                                buf_ready;
  logic signed [adnd_pkg::SampleW-1:0] pred_a_in, pred_b_in, lane1_pred;
  logic [adnd_pkg::IdxW-1:0]           idx_a_in, idx_b_in, lane1_idx;
  adnd_pkg::lane_res_t                 lane0_res, lane1_res;
  adnd_pkg::pcm_t                      pair;

  assign code_i.ready = buf_ready;
  assign in_fire      = code_i.valid && buf_ready;

  // A start flag zeroes both channels before this byte is decoded.
  always_comb begin
    if (code_i.start_of_stream) begin
      pred_a_in = '0;
      idx_a_in  = '0;
      pred_b_in = '0;
      idx_b_in  = '0;
    end else begin
      pred_a_in = pred_a_q;
      idx_a_in  = idx_a_q;
      pred_b_in = pred_b_q;
      idx_b_in  = idx_b_q;
    end
  end

  // Lane 0 always decodes the high nibble on channel A.
  adnd_lane u_lane0 (
    .code_i (code_i.code_byte[7:4]),
    .pred_i (pred_a_in),
    .idx_i  (idx_a_in),
    .res_o  (lane0_res)
  );

  // In stereo lane 1 runs on channel B; in mono it continues from lane 0.
  assign lane1_pred = stereo_q ? pred_b_in : lane0_res.sample;
  assign lane1_idx  = stereo_q ? idx_b_in  : lane0_res.idx;

  adnd_lane u_lane1 (
    .code_i (code_i.code_byte[3:0]),
    .pred_i (lane1_pred),
    .idx_i  (lane1_idx),
    .res_o  (lane1_res)
  );

  // Merge: route lane results back into the channel state.
  always_comb begin
    if (stereo_q) begin
      pred_a_d = lane0_res.sample;
      idx_a_d  = lane0_res.idx;
      pred_b_d = lane1_res.sample;
      idx_b_d  = lane1_res.idx;
    end else begin
      pred_a_d = lane1_res.sample;
      idx_a_d  = lane1_res.idx;
      pred_b_d = pred_b_in;
      idx_b_d  = idx_b_in;
    end
    pair.first_sample  = lane0_res.sample;
    pair.second_sample = lane1_res.sample;
    pair.last_pair     = code_i.end_of_stream;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_a_q <= '0;
      idx_a_q  <= '0;
      pred_b_q <= '0;
      idx_b_q  <= '0;
      stereo_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        stereo_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        pred_a_q <= pred_a_d;
        idx_a_q  <= idx_a_d;
        pred_b_q <= pred_b_d;
        idx_b_q  <= idx_b_d;
      end
    end
  end

  adnd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_fire),
    .data_i  (pair),
    .ready_o (buf_ready),
    .pcm_o   (pcm_o)
  );

  // Mono transactions without a start flag never disturb channel B.
  `ADND_ASSERT(a_mono_keeps_b,
               in_fire && !stereo_q && !code_i.start_of_stream
               |=> $stable(pred_b_q) && $stable(idx_b_q),
               "channel B changed in mono")
  // Step indices stay inside the step table.
  `ADND_ASSERT(a_idx_range,
               (idx_a_q <= adnd_pkg::MaxIdx) && (idx_b_q <= adnd_pkg::MaxIdx),
               "step index out of range")
  // Saturation never lets a predictor reach the most negative code.
  `ADND_ASSERT(a_pred_clamp,
               (pred_a_q != 16'sh8000) && (pred_b_q != 16'sh8000),
               "predictor escaped clamp")

endmodule

### rtl/adnd_lane.sv
// ---------------------------------------------------------------------------
// ADPCM nibble decoder lane
// Decodes one 4-bit code against one channel's predictor and step index.
// ---------------------------------------------------------------------------
module adnd_lane (
  input  logic [adnd_pkg::CodeW-1:0]          code_i,
  input  logic signed [adnd_pkg::SampleW-1:0] pred_i,
  input  logic [adnd_pkg::IdxW-1:0]           idx_i,
  output adnd_pkg::lane_res_t                 res_o
);

  logic [adnd_pkg::StepW-1:0]  step;
  logic [16:0]                 diff;
  logic signed [17:0]          sum;
  logic signed [6:0]           idx_sum;

  always_comb begin
    step = adnd_pkg::step_size(idx_i);
    diff = {5'd0, step[14:3]};
    if (code_i[0]) diff = diff + {4'd0, step[14:2]};
    if (code_i[1]) diff = diff + {3'd0, step[14:1]};
    if (code_i[2]) diff = diff + {2'd0, step};

    if (code_i[3]) sum = {{2{pred_i[15]}}, pred_i} - $signed({1'b0, diff});
    else           sum = {{2{pred_i[15]}}, pred_i} + $signed({1'b0, diff});

    if (sum > 18'(adnd_pkg::PredMax))      res_o.sample = adnd_pkg::PredMax;
    else if (sum < 18'(adnd_pkg::PredMin)) res_o.sample = adnd_pkg::PredMin;
    else                                   res_o.sample = sum[15:0];

    idx_sum = $signed({1'b0, idx_i}) + 7'(adnd_pkg::index_move(code_i[2:0]));
    if (idx_sum < 7'sd0)                                res_o.idx = '0;
    else if (idx_sum > $signed({1'b0, adnd_pkg::MaxIdx})) res_o.idx = adnd_pkg::MaxIdx;
    else                                                res_o.idx = idx_sum[5:0];
  end

endmodule

### rtl/adnd_out_buf.sv
// ---------------------------------------------------------------------------
// ADPCM nibble decoder output buffer
// Two-entry output register with skid slot between decoder and consumer.
// ---------------------------------------------------------------------------
module adnd_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  adnd_pkg::pcm_t data_i,
  output logic           ready_o,
  adnd_pcm_if.source     pcm_o
);

  logic           main_vld_q, main_vld_d;
  logic           skid_vld_q, skid_vld_d;
  adnd_pkg::pcm_t main_q, main_d;
  adnd_pkg::pcm_t skid_q, skid_d;
  logic           pop;

  assign pop     = main_vld_q && pcm_o.ready;
  assign ready_o = !skid_vld_q;

  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (pop) begin
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_vld_q || pop) begin
        main_d     = data_i;
        main_vld_d = 1'b1;
      end else begin
        skid_d     = data_i;
        skid_vld_d = 1'b1;
      end
    end else if (pop) begin
      main_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign pcm_o.valid         = main_vld_q;
  assign pcm_o.first_sample  = main_q.first_sample;
  assign pcm_o.second_sample = main_q.second_sample;
  assign pcm_o.last_pair     = main_q.last_pair;

endmodule
